FILE: rtl/core/cfir_pkg.sv
// Shared constants and types for the complex FIR filter.
package cfir_pkg;

	localparam int DEF_MAX_TAPS     = 32;
	localparam int DEF_SAMPLE_WIDTH = 16;

	localparam int ACC_W      = 40;
	localparam int COEF_IDX_W = 5;
	localparam int TAP_CNT_W  = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [TAP_CNT_W-1:0] TAP_CNT_RESET = TAP_CNT_W'(20);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CONJ = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TAPS = CFG_IDX_W'(1);

	// request kinds carried in tuser
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	typedef struct packed {
		logic shift;
		logic clear;
		logic conj;
	} cfir_ctrl_t;

endpackage

FILE: rtl/core/complex_fir_filter.sv
// Complex FIR filter top level: control sequencer, config registers and the row of tap cells.
//
//  port group  direction  contents
//  s_*         in         tuser req_type, tlast last_sample, tdata coeff_index/value_i/value_q
//  m_*         out        tlast frame_end, tdata out_i/out_q
//  cfg_*       in         cfg_index register number, cfg_data write value
//
// A coefficient load writes one tap's coefficient. A sample shifts into the delay line and
// each result then passes through the product registers, the partial sum ripples through
// the cell row and the output register is loaded; the next word is taken once the
// sequencer is idle again. A last sample adds tap_count-1 more such passes.
// A full output register stalls the sequencer with the sum held; input waits meanwhile.
// Reset clears coefficients, delay line and config (tap_count 20, no conjugation).
module complex_fir_filter import cfir_pkg::*; #(
	parameter int MAX_TAPS     = DEF_MAX_TAPS,
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         s_tvalid,
	output logic                                         s_tready,
	// coeff_index, value_i, value_q, zero pad
	input  logic [((COEF_IDX_W+2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
	// req_type
	input  logic                                         s_tuser,
	input  logic                                         s_tlast,
	output logic                                         m_tvalid,
	input  logic                                         m_tready,
	// out_i, out_q
	output logic [((2*ACC_W+7)/8)*8-1:0]                 m_tdata,
	output logic                                         m_tlast,
	input  logic                                         cfg_valid,
	output logic                                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]                         cfg_index,
	input  logic [CFG_DATA_W-1:0]                        cfg_data
);

	localparam int OUT_W    = ((2*ACC_W+7)/8)*8;
	localparam int TW       = $clog2(MAX_TAPS+1);
	localparam int CW       = $clog2(MAX_TAPS+2);
	localparam int VI_LO    = COEF_IDX_W;
	localparam int VQ_LO    = COEF_IDX_W + SAMPLE_WIDTH;
	localparam logic [CW-1:0] DONE_CNT = CW'(MAX_TAPS+1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_CALC = 2'b10
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           cnt_q;
	logic [TW-1:0]           tail_q;
	logic                    last_q;
	logic                    conj_q;
	logic [TAP_CNT_W-1:0]    taps_cfg_q;
	logic [TW-1:0]           taps;
	logic                    out_valid_q;
	logic signed [ACC_W-1:0] out_i_q, out_q_q;
	logic                    out_end_q;

	logic                    in_acc, smp_in, ld_in, done, load_out, tail_shift, frame_done;
	cfir_ctrl_t              ctrl;

	logic [COEF_IDX_W-1:0]          coeff_index;
	logic signed [SAMPLE_WIDTH-1:0] value_i, value_q, head_i, head_q;

	logic signed [SAMPLE_WIDTH-1:0] x_i_c [0:MAX_TAPS];
	logic signed [SAMPLE_WIDTH-1:0] x_q_c [0:MAX_TAPS];
	logic signed [ACC_W-1:0]        ps_i_c [0:MAX_TAPS];
	logic signed [ACC_W-1:0]        ps_q_c [0:MAX_TAPS];

	assign coeff_index = s_tdata[COEF_IDX_W-1:0];
	assign value_i     = s_tdata[VI_LO +: SAMPLE_WIDTH];
	assign value_q     = s_tdata[VQ_LO +: SAMPLE_WIDTH];

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	assign in_acc     = s_tvalid && s_tready;
	assign smp_in     = in_acc && (s_tuser == REQ_SAMPLE);
	assign ld_in      = in_acc && (s_tuser == REQ_LOAD);
	assign done       = (cnt_q == DONE_CNT);
	assign load_out   = (state_q == ST_CALC) && done && (!out_valid_q || m_tready);
	assign tail_shift = load_out && (tail_q != '0);
	assign frame_done = load_out && (tail_q == '0) && last_q;

	assign ctrl.shift = smp_in || tail_shift;
	assign ctrl.clear = frame_done;
	assign ctrl.conj  = conj_q;

	// tail passes feed zeros into the delay line
	assign head_i = tail_shift ? '0 : value_i;
	assign head_q = tail_shift ? '0 : value_q;

	always_comb begin
		if (taps_cfg_q == '0) begin
			taps = TW'(1);
		end else if (int'(taps_cfg_q) > MAX_TAPS) begin
			taps = TW'(MAX_TAPS);
		end else begin
			taps = TW'(taps_cfg_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conj_q     <= 1'b0;
			taps_cfg_q <= TAP_CNT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CONJ: begin
					conj_q <= cfg_data[0];
				end
				REG_TAPS: begin
					taps_cfg_q <= cfg_data[TAP_CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			tail_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (smp_in) begin
						state_q <= ST_CALC;
						cnt_q   <= '0;
						last_q  <= s_tlast;
						tail_q  <= s_tlast ? taps - TW'(1) : '0;
					end
				end
				ST_CALC: begin
					if (!done) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (load_out) begin
						if (tail_q != '0) begin
							tail_q <= tail_q - TW'(1);
							cnt_q  <= '0;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_i_q   <= ps_i_c[MAX_TAPS];
			out_q_q   <= ps_q_c[MAX_TAPS];
			out_end_q <= last_q && (tail_q == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_end_q;
	assign m_tdata  = OUT_W'({out_q_q, out_i_q});

	assign x_i_c[0]  = head_i;
	assign x_q_c[0]  = head_q;
	assign ps_i_c[0] = '0;
	assign ps_q_c[0] = '0;

	for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
		logic coef_we;
		logic tap_en;

		assign coef_we = ld_in && (int'(coeff_index) == g);
		assign tap_en  = (g < int'(taps));

		cfir_cell #(
			.SAMPLE_WIDTH(SAMPLE_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.coef_we    (coef_we),
			.coef_i     (value_i),
			.coef_q     (value_q),
			.tap_en     (tap_en),
			.x_in_i     (x_i_c[g]),
			.x_in_q     (x_q_c[g]),
			.x_out_i    (x_i_c[g+1]),
			.x_out_q    (x_q_c[g+1]),
			.psum_in_i  (ps_i_c[g]),
			.psum_in_q  (ps_q_c[g]),
			.psum_out_i (ps_i_c[g+1]),
			.psum_out_q (ps_q_c[g+1])
		);
	end

endmodule

FILE: rtl/core/cfir_cell.sv
// One filter tap: coefficient, delay-line sample, complex product and partial sum stage.
module cfir_cell import cfir_pkg::*; #(
	parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cfir_ctrl_t                     ctrl,
	input  logic                           coef_we,
	input  logic signed [SAMPLE_WIDTH-1:0] coef_i,
	input  logic signed [SAMPLE_WIDTH-1:0] coef_q,
	input  logic                           tap_en,
	input  logic signed [SAMPLE_WIDTH-1:0] x_in_i,
	input  logic signed [SAMPLE_WIDTH-1:0] x_in_q,
	output logic signed [SAMPLE_WIDTH-1:0] x_out_i,
	output logic signed [SAMPLE_WIDTH-1:0] x_out_q,
	input  logic signed [ACC_W-1:0]        psum_in_i,
	input  logic signed [ACC_W-1:0]        psum_in_q,
	output logic signed [ACC_W-1:0]        psum_out_i,
	output logic signed [ACC_W-1:0]        psum_out_q
);

	localparam int PROD_W = 2 * SAMPLE_WIDTH;
	localparam int SUM_W  = PROD_W + 1;
	localparam int EXT_W  = (SUM_W > ACC_W) ? SUM_W : ACC_W;

	logic signed [SAMPLE_WIDTH-1:0] x_i_q, x_q_q, w_i_q, w_q_q;
	logic signed [PROD_W-1:0]       p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic signed [SUM_W-1:0]        re_sum, im_sum;
	logic signed [EXT_W-1:0]        re_ext, im_ext;
	logic signed [ACC_W-1:0]        re_add, im_add;
	logic signed [ACC_W-1:0]        psum_i_q, psum_q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_i_q <= '0;
			x_q_q <= '0;
			w_i_q <= '0;
			w_q_q <= '0;
		end else begin
			if (ctrl.clear) begin
				x_i_q <= '0;
				x_q_q <= '0;
			end else if (ctrl.shift) begin
				x_i_q <= x_in_i;
				x_q_q <= x_in_q;
			end
			if (coef_we) begin
				w_i_q <= coef_i;
				w_q_q <= coef_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		p_rr_s1 <= x_i_q * w_i_q;
		p_ii_s1 <= x_q_q * w_q_q;
		p_ri_s1 <= x_i_q * w_q_q;
		p_ir_s1 <= x_q_q * w_i_q;
	end

	// conjugate negates the coefficient's imaginary part
	always_comb begin
		if (ctrl.conj) begin
			re_sum = SUM_W'(p_rr_s1) + SUM_W'(p_ii_s1);
			im_sum = SUM_W'(p_ir_s1) - SUM_W'(p_ri_s1);
		end else begin
			re_sum = SUM_W'(p_rr_s1) - SUM_W'(p_ii_s1);
			im_sum = SUM_W'(p_ri_s1) + SUM_W'(p_ir_s1);
		end
		re_ext = EXT_W'(re_sum);
		im_ext = EXT_W'(im_sum);
		re_add = tap_en ? re_ext[ACC_W-1:0] : '0;
		im_add = tap_en ? im_ext[ACC_W-1:0] : '0;
	end

	always_ff @(posedge clk) begin
		psum_i_q <= psum_in_i + re_add;
		psum_q_q <= psum_in_q + im_add;
	end

	assign x_out_i    = x_i_q;
	assign x_out_q    = x_q_q;
	assign psum_out_i = psum_i_q;
	assign psum_out_q = psum_q_q;

endmodule
